// ----- hdl/csp_pkg.sv -----
// Shared types, codes and a width helper for the cubed-sphere panel remap.
package csp_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int COORD_WIDTH_DEF = 20;
   localparam int PANEL_WIDTH     = 3;
   localparam int STATUS_WIDTH    = 3;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_BAD_SRC = 3'd1,
      STATUS_BAD_DST = 3'd2,
      STATUS_BEHIND  = 3'd3,
      STATUS_SAT     = 3'd4
   } status_type;

   localparam logic [PANEL_WIDTH-1:0] PANEL_EQ0   = 3'd0;
   localparam logic [PANEL_WIDTH-1:0] PANEL_EQ1   = 3'd1;
   localparam logic [PANEL_WIDTH-1:0] PANEL_EQ2   = 3'd2;
   localparam logic [PANEL_WIDTH-1:0] PANEL_EQ3   = 3'd3;
   localparam logic [PANEL_WIDTH-1:0] PANEL_NORTH = 3'd4;
   localparam logic [PANEL_WIDTH-1:0] PANEL_SOUTH = 3'd5;

   // Width of the rotated vector components: holds the negated most negative
   // coordinate and plus or minus one.
   function automatic int vwidth(input int cw, input int fb);
      return (cw + 1 > fb + 2) ? cw + 1 : fb + 2;
   endfunction

endpackage

// ----- hdl/csp_fifo.sv -----
// Two-entry queue with valid/ready on both sides.
module csp_fifo #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             ready,
   input  logic [WIDTH-1:0] wdata,
   output logic             valid,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign ready   = (count_ff != 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push & ready;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- hdl/csp_front.sv -----
// Front end: accepts an item, rotates it onto the destination face, classifies it.
module csp_front #(
   parameter int FRAC_BITS   = csp_pkg::FRAC_BITS_DEF,
   parameter int COORD_WIDTH = csp_pkg::COORD_WIDTH_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        push,
   output logic                                        full,
   input  logic signed [COORD_WIDTH-1:0]               x_in,
   input  logic signed [COORD_WIDTH-1:0]               y_in,
   input  logic [csp_pkg::PANEL_WIDTH-1:0]             src_panel,
   input  logic [csp_pkg::PANEL_WIDTH-1:0]             dst_panel,
   output logic                                        item_valid,
   input  logic                                        item_ready,
   output logic [csp_pkg::vwidth(COORD_WIDTH, FRAC_BITS)-1:0] a_mag,
   output logic                                        a_neg,
   output logic [csp_pkg::vwidth(COORD_WIDTH, FRAC_BITS)-1:0] b_mag,
   output logic                                        b_neg,
   output logic [csp_pkg::vwidth(COORD_WIDTH, FRAC_BITS)-1:0] den,
   output csp_pkg::status_type                         status
);
   import csp_pkg::*;

   localparam int VW = vwidth(COORD_WIDTH, FRAC_BITS);
   localparam logic signed [VW-1:0] ONE = VW'(1) << FRAC_BITS;

   logic signed [VW-1:0] px, py, gx, gy, gz, a, b, c;
   logic [VW-1:0]        a_mag_in, b_mag_in, den_in;
   logic [VW-1:0]        a_mag_ff, b_mag_ff, den_ff;
   logic                 a_neg_in, b_neg_in, a_neg_ff, b_neg_ff;
   status_type           status_in, status_ff;
   logic                 valid_ff, valid_in;
   logic                 accept;

   assign full   = valid_ff & ~item_ready;
   assign accept = push & ~full;

   always_comb begin
      px        = VW'(x_in);
      py        = VW'(y_in);
      gx        = '0;
      gy        = '0;
      gz        = '0;
      a         = '0;
      b         = '0;
      c         = '0;
      status_in = STATUS_OK;

      case (src_panel)
         PANEL_EQ0: begin
            gx = ONE;  gy = px;   gz = py;
         end
         PANEL_EQ1: begin
            gx = -px;  gy = ONE;  gz = py;
         end
         PANEL_EQ2: begin
            gx = -ONE; gy = -px;  gz = py;
         end
         PANEL_EQ3: begin
            gx = px;   gy = -ONE; gz = py;
         end
         PANEL_NORTH: begin
            gx = -py;  gy = px;   gz = ONE;
         end
         PANEL_SOUTH: begin
            gx = py;   gy = px;   gz = -ONE;
         end
         default: begin
            status_in = STATUS_BAD_SRC;
         end
      endcase

      case (dst_panel)
         PANEL_EQ0: begin
            a = gy;  b = gz;  c = gx;
         end
         PANEL_EQ1: begin
            a = -gx; b = gz;  c = gy;
         end
         PANEL_EQ2: begin
            a = -gy; b = gz;  c = -gx;
         end
         PANEL_EQ3: begin
            a = gx;  b = gz;  c = -gy;
         end
         PANEL_NORTH: begin
            a = gy;  b = -gx; c = gz;
         end
         PANEL_SOUTH: begin
            a = gy;  b = gx;  c = -gz;
         end
         default: begin
            if (status_in == STATUS_OK) begin
               status_in = STATUS_BAD_DST;
            end
         end
      endcase

      if (status_in == STATUS_OK && (c[VW-1] || c == '0)) begin
         status_in = STATUS_BEHIND;
      end

      a_neg_in = a[VW-1];
      b_neg_in = b[VW-1];
      a_mag_in = a[VW-1] ? -a : a;
      b_mag_in = b[VW-1] ? -b : b;
      den_in   = c;
      valid_in = accept | (valid_ff & ~item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_mag_ff  <= a_mag_in;
         b_mag_ff  <= b_mag_in;
         a_neg_ff  <= a_neg_in;
         b_neg_ff  <= b_neg_in;
         den_ff    <= den_in;
         status_ff <= status_in;
      end
   end

   assign item_valid = valid_ff;
   assign a_mag      = a_mag_ff;
   assign b_mag      = b_mag_ff;
   assign a_neg      = a_neg_ff;
   assign b_neg      = b_neg_ff;
   assign den        = den_ff;
   assign status     = status_ff;

endmodule

// ----- hdl/csp_div.sv -----
// Back end: two-lane pipelined restoring divider, one quotient bit per stage.
module csp_div #(
   parameter int FRAC_BITS   = csp_pkg::FRAC_BITS_DEF,
   parameter int COORD_WIDTH = csp_pkg::COORD_WIDTH_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_pop,
   input  logic [csp_pkg::vwidth(COORD_WIDTH, FRAC_BITS)-1:0] a_mag,
   input  logic                                        a_neg,
   input  logic [csp_pkg::vwidth(COORD_WIDTH, FRAC_BITS)-1:0] b_mag,
   input  logic                                        b_neg,
   input  logic [csp_pkg::vwidth(COORD_WIDTH, FRAC_BITS)-1:0] den,
   input  csp_pkg::status_type                         status_in,
   output logic                                        res_valid,
   input  logic                                        res_ready,
   output logic [COORD_WIDTH-1:0]                      res_x,
   output logic [COORD_WIDTH-1:0]                      res_y,
   output csp_pkg::status_type                         res_status
);
   import csp_pkg::*;

   localparam int VW   = vwidth(COORD_WIDTH, FRAC_BITS);
   localparam int LW   = VW + ((FRAC_BITS > COORD_WIDTH) ? FRAC_BITS : COORD_WIDTH);
   localparam int NS   = COORD_WIDTH + 1;
   localparam int LAST = NS - 1;
   localparam logic [COORD_WIDTH-1:0] HALF = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [NS-1:0]          valid_ff, valid_in;
   logic [LW-1:0]          ra_ff [NS];
   logic [LW-1:0]          ra_in [NS];
   logic [LW-1:0]          rb_ff [NS];
   logic [LW-1:0]          rb_in [NS];
   logic [COORD_WIDTH-1:0] qa_ff [NS];
   logic [COORD_WIDTH-1:0] qa_in [NS];
   logic [COORD_WIDTH-1:0] qb_ff [NS];
   logic [COORD_WIDTH-1:0] qb_in [NS];
   logic [VW-1:0]          d_ff  [NS];
   logic [VW-1:0]          d_in  [NS];
   status_type             st_ff [NS];
   status_type             st_in [NS];
   logic [NS-1:0]          na_ff, na_in, nb_ff, nb_in;
   logic [NS-1:0]          biga_ff, biga_in, bigb_ff, bigb_in;
   logic [LW-1:0]          trial [NS];
   logic [LW-1:0]          den_top;
   logic                   en;
   logic [COORD_WIDTH-1:0] maxa, maxb, qa_sat, qb_sat;
   logic                   sata, satb;

   // Advance the whole pipe unless the finished item cannot leave.
   assign en     = ~valid_ff[LAST] | res_ready;
   assign in_pop = en & in_valid;

   always_comb begin
      // Stage 0: quotient at or above 2^COORD_WIDTH saturates outright.
      den_top     = LW'(den) << COORD_WIDTH;
      valid_in[0] = in_valid;
      ra_in[0]    = LW'(a_mag) << FRAC_BITS;
      rb_in[0]    = LW'(b_mag) << FRAC_BITS;
      biga_in[0]  = (LW'(a_mag) << FRAC_BITS) >= den_top;
      bigb_in[0]  = (LW'(b_mag) << FRAC_BITS) >= den_top;
      qa_in[0]    = '0;
      qb_in[0]    = '0;
      d_in[0]     = den;
      st_in[0]    = status_in;
      na_in[0]    = a_neg;
      nb_in[0]    = b_neg;
      trial[0]    = '0;

      for (int k = 1; k < NS; k++) begin
         trial[k]    = LW'(d_ff[k-1]) << (COORD_WIDTH - k);
         valid_in[k] = valid_ff[k-1];
         d_in[k]     = d_ff[k-1];
         st_in[k]    = st_ff[k-1];
         na_in[k]    = na_ff[k-1];
         nb_in[k]    = nb_ff[k-1];
         biga_in[k]  = biga_ff[k-1];
         bigb_in[k]  = bigb_ff[k-1];
         ra_in[k]    = ra_ff[k-1];
         rb_in[k]    = rb_ff[k-1];
         qa_in[k]    = qa_ff[k-1];
         qb_in[k]    = qb_ff[k-1];
         if (ra_ff[k-1] >= trial[k]) begin
            ra_in[k]                  = ra_ff[k-1] - trial[k];
            qa_in[k][COORD_WIDTH - k] = 1'b1;
         end
         if (rb_ff[k-1] >= trial[k]) begin
            rb_in[k]                  = rb_ff[k-1] - trial[k];
            qb_in[k][COORD_WIDTH - k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NS; k++) begin
            ra_ff[k] <= ra_in[k];
            rb_ff[k] <= rb_in[k];
            qa_ff[k] <= qa_in[k];
            qb_ff[k] <= qb_in[k];
            d_ff[k]  <= d_in[k];
            st_ff[k] <= st_in[k];
         end
         na_ff   <= na_in;
         nb_ff   <= nb_in;
         biga_ff <= biga_in;
         bigb_ff <= bigb_in;
      end
   end

   // Clamp to the signed range, apply the sign, zero on error.
   always_comb begin
      maxa   = na_ff[LAST] ? HALF : HALF - 1'b1;
      maxb   = nb_ff[LAST] ? HALF : HALF - 1'b1;
      sata   = biga_ff[LAST] | (qa_ff[LAST] > maxa);
      satb   = bigb_ff[LAST] | (qb_ff[LAST] > maxb);
      qa_sat = sata ? maxa : qa_ff[LAST];
      qb_sat = satb ? maxb : qb_ff[LAST];
      if (st_ff[LAST] != STATUS_OK) begin
         res_x      = '0;
         res_y      = '0;
         res_status = st_ff[LAST];
      end else begin
         res_x      = na_ff[LAST] ? -qa_sat : qa_sat;
         res_y      = nb_ff[LAST] ? -qb_sat : qb_sat;
         res_status = (sata | satb) ? STATUS_SAT : STATUS_OK;
      end
   end

   assign res_valid = valid_ff[LAST];

endmodule

// ----- hdl/cubed_sphere_panel_remap.sv -----
// Cubed-sphere gnomonic panel remap: top level.
//
// Each item carries gnomonic (x, y) on a source cube face plus source and
// destination face ids; the result is the same ray's gnomonic coordinates on
// the destination face, each quotient truncated toward zero and saturated,
// with a status code. It takes one item per clock while full is low and
// returns one result per item, in order. The restoring divider in the back
// end resolves one quotient bit per pipeline stage for both coordinates at
// once. A small queue between the classifying front end and the divider, and
// another at the output, let either side stall without losing or repeating
// items.
module cubed_sphere_panel_remap #(
   parameter int FRAC_BITS   = csp_pkg::FRAC_BITS_DEF,
   parameter int COORD_WIDTH = csp_pkg::COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic signed [COORD_WIDTH-1:0]      req_x_in,
   input  logic signed [COORD_WIDTH-1:0]      req_y_in,
   input  logic [csp_pkg::PANEL_WIDTH-1:0]    req_src_panel,
   input  logic [csp_pkg::PANEL_WIDTH-1:0]    req_dst_panel,
   output logic                               empty,
   input  logic                               pop,
   output logic signed [COORD_WIDTH-1:0]      rsp_x_out,
   output logic signed [COORD_WIDTH-1:0]      rsp_y_out,
   output logic [csp_pkg::STATUS_WIDTH-1:0]   rsp_status
);
   import csp_pkg::*;

   localparam int VW     = vwidth(COORD_WIDTH, FRAC_BITS);
   localparam int MID_W  = 3 * VW + 2 + STATUS_WIDTH;
   localparam int OUT_W  = 2 * COORD_WIDTH + STATUS_WIDTH;

   logic                    fe_valid, mid_ready, mid_valid, mid_pop;
   logic [VW-1:0]           fe_a_mag, fe_b_mag, fe_den;
   logic                    fe_a_neg, fe_b_neg;
   status_type              fe_status;
   logic [MID_W-1:0]        mid_wdata, mid_rdata;
   logic [VW-1:0]           mid_a_mag, mid_b_mag, mid_den;
   logic                    mid_a_neg, mid_b_neg;
   logic [STATUS_WIDTH-1:0] mid_status_bits;
   logic                    res_valid, res_ready;
   logic [COORD_WIDTH-1:0]  res_x, res_y;
   status_type              res_status;
   logic [OUT_W-1:0]        out_wdata, out_rdata;
   logic                    out_valid;

   csp_front #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .x_in       (req_x_in),
      .y_in       (req_y_in),
      .src_panel  (req_src_panel),
      .dst_panel  (req_dst_panel),
      .item_valid (fe_valid),
      .item_ready (mid_ready),
      .a_mag      (fe_a_mag),
      .a_neg      (fe_a_neg),
      .b_mag      (fe_b_mag),
      .b_neg      (fe_b_neg),
      .den        (fe_den),
      .status     (fe_status)
   );

   assign mid_wdata = {fe_a_mag, fe_a_neg, fe_b_mag, fe_b_neg, fe_den, fe_status};

   csp_fifo #(
      .WIDTH (MID_W)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (fe_valid),
      .ready (mid_ready),
      .wdata (mid_wdata),
      .valid (mid_valid),
      .pop   (mid_pop),
      .rdata (mid_rdata)
   );

   assign {mid_a_mag, mid_a_neg, mid_b_mag, mid_b_neg, mid_den, mid_status_bits} = mid_rdata;

   csp_div #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_pop     (mid_pop),
      .a_mag      (mid_a_mag),
      .a_neg      (mid_a_neg),
      .b_mag      (mid_b_mag),
      .b_neg      (mid_b_neg),
      .den        (mid_den),
      .status_in  (status_type'(mid_status_bits)),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_x      (res_x),
      .res_y      (res_y),
      .res_status (res_status)
   );

   assign out_wdata = {res_x, res_y, res_status};

   csp_fifo #(
      .WIDTH (OUT_W)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (res_valid),
      .ready (res_ready),
      .wdata (out_wdata),
      .valid (out_valid),
      .pop   (pop),
      .rdata (out_rdata)
   );

   assign empty = ~out_valid;
   assign {rsp_x_out, rsp_y_out, rsp_status} = out_rdata;

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && (rsp_status == STATUS_BAD_SRC || rsp_status == STATUS_BAD_DST ||
                 rsp_status == STATUS_BEHIND)
      |-> rsp_x_out == '0 && rsp_y_out == '0)
      else $error("error result with nonzero coordinates");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(res_x) && $stable(res_y)
                                  && $stable(res_status))
      else $error("divider dropped or changed a stalled item");

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      mid_valid && !mid_pop && !fe_valid |=> mid_valid && $stable(mid_rdata))
      else $error("middle queue lost an item");

endmodule
